// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam logic       FUNC_GET  = 1'b0;
  localparam logic       FUNC_PUT  = 1'b1;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic               func;
    logic signed [31:0] key;
    logic signed [31:0] put_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic resolve;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } sts_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// A request accepted in the idle state steps through the match, resolve, update and
// finish states before its result is registered. The input stalls until the finish
// step, so a new request waits for the last to finish; a held result delays that step.
// Reset is synchronous and active low; it clears all valid bits and the occupancy,
// and sets the capacity to sixteen, with no clearing pass over the value memory.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lkvc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lkvc_pkg::rsp_t out_data,
  input  logic           cfg_wr_en,
  input  logic [4:0]     cfg_wr_data
);
  import lkvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkvc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("sequencer issued more than one command");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.compare)
    else $error("accepted request did not enter the match step");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.compare || cmd.resolve || cmd.update) |-> in_stall)
    else $error("input not stalled while a request is in flight");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished request produced no result");

endmodule

// ===== rtl/lkvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lkvc_ctrl.sv =====
// Sequencer that steps one request through match, resolve, update and finish.
module lkvc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lkvc_pkg::sts_t sts,
  output lkvc_pkg::cmd_t cmd
);
  import lkvc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MATCH   = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_UPDATE  = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.compare = 1'b1;
        state_nxt   = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lkvc_dpath.sv =====
// Entry cells, recency ranks, value memory and result register of the cache.
module lkvc_dpath #(
  parameter int ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lkvc_pkg::req_t in_data,
  input  logic           cfg_wr_en,
  input  logic [4:0]     cfg_wr_data,
  input  lkvc_pkg::cmd_t cmd,
  output lkvc_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output lkvc_pkg::rsp_t out_data
);
  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > 5) ? CW : 5;

  req_t               req_r;
  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        key_r  [ENTRIES];
  logic [IW-1:0]      rank_r [ENTRIES];
  logic [CW-1:0]      occ_r;
  logic [4:0]         cap_r;
  logic [ENTRIES-1:0] match_r;
  logic [ENTRIES-1:0] victim_r;
  logic               hit_r;
  logic               fill_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      old_rank_r;
  logic               out_valid_r;
  rsp_t               out_data_r;

  logic [IW-1:0]      lru_rank;
  logic               room;
  logic               any_hit;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      hit_rank;
  logic [IW-1:0]      vic_idx;
  logic               do_update;
  logic               ram_we;
  logic [31:0]        ram_rdata;

  assign lru_rank  = IW'(occ_r - CW'(1));
  assign room      = (occ_r != CW'(ENTRIES)) &&
                     ((MW'(occ_r) < MW'(cap_r)) || (cap_r == 5'd0 && occ_r == '0));
  assign do_update = hit_r || (req_r.func == FUNC_PUT);
  assign ram_we    = cmd.update && (req_r.func == FUNC_PUT);

  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    hit_rank = '0;
    vic_idx  = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      any_hit  = any_hit | match_r[j];
      hit_idx  = hit_idx  | (match_r[j]  ? IW'(j)    : '0);
      hit_rank = hit_rank | (match_r[j]  ? rank_r[j] : '0);
      vic_idx  = vic_idx  | (victim_r[j] ? IW'(j)    : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.compare) begin
      for (int j = 0; j < ENTRIES; j++) begin
        match_r[j]  <= valid_r[j] && (key_r[j] == req_r.key);
        victim_r[j] <= valid_r[j] && (rank_r[j] == lru_rank);
      end
    end
    if (cmd.resolve) begin
      hit_r  <= any_hit;
      fill_r <= !any_hit && (req_r.func == FUNC_PUT) && room;
      priority if (any_hit) begin
        idx_r      <= hit_idx;
        old_rank_r <= hit_rank;
      end else if (room) begin
        idx_r      <= IW'(occ_r);
        old_rank_r <= lru_rank;
      end else begin
        idx_r      <= vic_idx;
        old_rank_r <= lru_rank;
      end
    end
    if (cmd.update && do_update) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (IW'(j) == idx_r) begin
          rank_r[j] <= '0;
          key_r[j]  <= req_r.key;
        end else if (valid_r[j] && (fill_r || rank_r[j] < old_rank_r)) begin
          rank_r[j] <= rank_r[j] + IW'(1);
        end
      end
    end
    if (cmd.finish) begin
      out_data_r.hit        <= hit_r;
      out_data_r.read_value <= (hit_r && req_r.func == FUNC_GET) ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.update && fill_r) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (IW'(j) == idx_r) begin
            valid_r[j] <= 1'b1;
          end
        end
        occ_r <= occ_r + CW'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  lkvc_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (req_r.put_value),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign sts.out_hold = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LRU key-value cache: directed and random requests.
`timescale 1ns / 1ps

module tb;
  import lkvc_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 12;
  localparam logic [31:0] KMIN = 32'h8000_0000;
  localparam logic [31:0] KMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic        is_cfg;
    logic [4:0]  cap;
    logic        func;
    logic [31:0] key;
    logic [31:0] val;
    logic        typed;
    logic        e_hit;
    logic [31:0] e_val;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 5'd0,  FUNC_GET, 32'h0,  32'h0,         1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, KMIN,   KMAX,          1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, KMAX,   KMIN,          1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, KMIN,   32'h0,         1'b1, 1'b1, KMAX},
    '{1'b0, 5'd0,  FUNC_GET, KMAX,   32'h0,         1'b1, 1'b1, KMIN},
    '{1'b0, 5'd0,  FUNC_PUT, KMAX,   ALL1,          1'b1, 1'b1, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, KMAX,   32'h5A5A_5A5A, 1'b1, 1'b1, ALL1},
    '{1'b0, 5'd0,  FUNC_GET, ALL1,   32'h0,         1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, 32'h0,  32'h0,         1'b1, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, 32'h0,  ALL1,          1'b1, 1'b1, 32'h0},
    '{1'b1, 5'd0,  FUNC_GET, 32'h0,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, 32'd5,  32'd55,        1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, KMIN,   32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, 32'd5,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, 32'd6,  32'd66,        1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, KMAX,   32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, 32'd5,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd31, FUNC_GET, 32'h0,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, 32'd7,  32'd77,        1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, 32'd6,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd1,  FUNC_GET, 32'h0,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, 32'd8,  32'd88,        1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_GET, 32'd7,  32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  FUNC_PUT, 32'd9,  ALL1,          1'b0, 1'b0, 32'h0}
  };

  localparam int PHASES = 8;
  int         phase_cap   [PHASES] = '{16, 1, 4, 31, 0, 7, 16, 3};
  idle_mode_t phase_mode  [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                       IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
  int         phase_items [PHASES] = '{120, 100, 120, 120, 100, 120, 140, 110};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_wr_en;
  logic [4:0] cfg_wr_data;

  logic        line_valid [SLOTS];
  logic [31:0] line_key   [SLOTS];
  logic [31:0] line_value [SLOTS];
  int          line_age   [SLOTS];
  int          lines_used;
  logic [4:0]  capacity_reg;

  rsp_t pending_rsp_q [$];
  int   err_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;

  lru_key_value_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int effective_capacity(input logic [4:0] c);
    if (c == 5'd0) return 1;
    if (c > SLOTS) return SLOTS;
    return int'(c);
  endfunction

  function automatic void make_most_recent(input int idx);
    int old;
    old = line_age[idx];
    for (int j = 0; j < SLOTS; j++) begin
      if (line_valid[j] && line_age[j] < old) line_age[j]++;
    end
    line_age[idx] = 0;
  endfunction

  function automatic rsp_t cache_apply(input req_t r);
    rsp_t rsp;
    int   idx;
    int   slot;
    int   victim;
    idx = -1;
    slot = -1;
    victim = -1;
    for (int j = 0; j < SLOTS; j++) begin
      if (idx < 0 && line_valid[j] && line_key[j] == r.key) idx = j;
    end
    rsp.hit = (idx >= 0);
    rsp.read_value = '0;
    if (r.func == FUNC_GET) begin
      if (idx >= 0) begin
        rsp.read_value = line_value[idx];
        make_most_recent(idx);
      end
      return rsp;
    end
    if (idx >= 0) begin
      line_value[idx] = r.put_value;
      make_most_recent(idx);
      return rsp;
    end
    if (lines_used < effective_capacity(capacity_reg)) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (slot < 0 && !line_valid[j]) slot = j;
      end
    end
    if (slot >= 0) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (line_valid[j]) line_age[j]++;
      end
      line_valid[slot] = 1'b1;
      line_key[slot] = r.key;
      line_value[slot] = r.put_value;
      line_age[slot] = 0;
      lines_used++;
      return rsp;
    end
    for (int j = 0; j < SLOTS; j++) begin
      if (line_valid[j] && (victim < 0 || line_age[j] > line_age[victim])) victim = j;
    end
    if (victim >= 0) begin
      line_key[victim] = r.key;
      line_value[victim] = r.put_value;
      make_most_recent(victim);
    end
    return rsp;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t predicted;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = cache_apply(r);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic drain_pending();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] c);
    drain_pending();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = c;
    @(posedge clk);
    capacity_reg = c;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return KMIN;
      1: return KMAX;
      2: return 32'h0;
      default: return ALL1;
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall = (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual hit %0d value %0h",
                 $time, out_data.hit, out_data.read_value);
        err_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data.hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0d, actual %0d",
                   $time, want.hit, out_data.hit);
          err_count++;
        end
        if (out_data.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0h, actual %0h",
                   $time, want.read_value, out_data.read_value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_key_value_cache verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_t        r;
    rsp_t        typed_rsp;
    logic [31:0] key_pool [$];
    int          pool_size;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    capacity_reg = CAP_RESET;
    lines_used = 0;
    for (int j = 0; j < SLOTS; j++) begin
      line_valid[j] = 1'b0;
      line_key[j] = '0;
      line_value[j] = '0;
      line_age[j] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].is_cfg) begin
        write_capacity(dir_rows[i].cap);
      end else begin
        r.func = dir_rows[i].func;
        r.key = dir_rows[i].key;
        r.put_value = dir_rows[i].val;
        typed_rsp.hit = dir_rows[i].e_hit;
        typed_rsp.read_value = dir_rows[i].e_val;
        send_request(r, dir_rows[i].typed, typed_rsp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p][4:0]);
      send_idle_pct = (phase_mode[p] == IDLE_SEND) ? 88 :
                      (phase_mode[p] == IDLE_BOTH) ? 13 : 0;
      recv_stall_pct = (phase_mode[p] == IDLE_RECV) ? 88 :
                       (phase_mode[p] == IDLE_BOTH) ? 13 : 0;
      key_pool.delete();
      pool_size = effective_capacity(capacity_reg) +
                  $urandom_range(1, effective_capacity(capacity_reg) + 3);
      for (int k = 0; k < pool_size; k++) begin
        key_pool.push_back(($urandom_range(0, 7) == 0) ? pick_extreme() : $urandom);
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        if ($urandom_range(0, 39) == 0) drain_pending();
        r.func = $urandom_range(0, 1) ? FUNC_PUT : FUNC_GET;
        r.key = ($urandom_range(0, 9) == 0) ? $urandom :
                key_pool[$urandom_range(0, key_pool.size() - 1)];
        r.put_value = ($urandom_range(0, 9) == 0) ? pick_extreme() : $urandom;
        send_request(r, 1'b0, '0);
      end
    end

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

endmodule

// ===== lru_key_value_cache.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dpath.sv
rtl/lru_key_value_cache.sv
verif/tb.sv
